### hdl/bhg_pkg.sv
`timescale 1ns / 1ps

package bhg_pkg;

  typedef enum logic [2:0] {
    OP_PRESS    = 3'd0,
    OP_HOLD     = 3'd1,
    OP_HOLD_REL = 3'd2,
    OP_LONG     = 3'd3,
    OP_LONG_REL = 3'd4,
    OP_TICK     = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    G_PRESS   = 3'd0,
    G_DELETE  = 3'd1,
    G_WIFI    = 3'd2,
    G_PAIR    = 3'd3,
    G_KICKOUT = 3'd4,
    G_KICKINC = 3'd5
  } gesture_t;

  localparam logic [1:0] CFG_PAIR_HOLD      = 2'd0;
  localparam logic [1:0] CFG_KICKOUT_HOLD   = 2'd1;
  localparam logic [1:0] CFG_KICKOUT_EXPIRE = 2'd2;

  localparam logic [31:0] PAIR_HOLD_RST      = 32'd5000000;
  localparam logic [31:0] KICKOUT_HOLD_RST   = 32'd3000000;
  localparam logic [31:0] KICKOUT_EXPIRE_RST = 32'd10000000;

  localparam logic [1:0] KICKOUT_LIMIT = 2'd3;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = 3;
  localparam int QCNT_W = 4;

  typedef struct packed {
    gesture_t   gesture;
    logic [1:0] which_button;
    logic       last;
  } result_t;

  // results produced by one item, at most two
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

### hdl/button_hold_gesture_controller_core.sv
`timescale 1ns / 1ps
// an item is captured in the input register, evaluated from it, and its results are queued.
// throughput: one item per cycle while s_axis_tready is high; results drain one per cycle,
// so two-result items or a stalled result side push the 8-entry queue past four entries
// (six when no item is in flight) and s_axis_tready drops
// reset: synchronous, clears all button state, the kick-out count, the queue and restores
// the register reset values

module button_hold_gesture_controller_core #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // operation[2:0], button[4:3], now_us[36:5], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // gesture[2:0], which_button[4:3], zero pad
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import bhg_pkg::*;

  logic              load;
  logic              busy;
  push_t             push;
  result_t           head;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] reserve;

  // keep room for two results of the item in flight plus two of the next one
  assign reserve       = busy ? QCNT_W'(4) : QCNT_W'(2);
  assign s_axis_tready = (QCNT_W'(QDEPTH) - count) >= reserve;
  assign load          = s_axis_tvalid && s_axis_tready;

  bhg_core #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .load      (load),
    .op_in     (op_t'(s_axis_tdata[2:0])),
    .button_in (s_axis_tdata[4:3]),
    .now_in    (s_axis_tdata[36:5]),
    .busy      (busy),
    .push      (push)
  );

  bhg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_axis_tvalid && m_axis_tready),
    .not_empty (m_axis_tvalid),
    .head      (head),
    .count     (count)
  );

  assign m_axis_tdata = {3'b000, head.which_button, head.gesture};
  assign m_axis_tlast = head.last;

endmodule

### hdl/bhg_core.sv
`timescale 1ns / 1ps

module bhg_core #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               load,
  input  bhg_pkg::op_t       op_in,
  input  logic [1:0]         button_in,
  input  logic [31:0]        now_in,
  output logic               busy,
  output bhg_pkg::push_t     push
);
  import bhg_pkg::*;

  localparam int BW = (NUM_BUTTONS > 2) ? 2 : 1;

  logic [31:0] pair_hold_us;
  logic [31:0] kickout_hold_us;
  logic [31:0] kickout_expire_us;

  logic        in_valid;
  op_t         in_op;
  logic [1:0]  in_button;
  logic [31:0] in_now;

  logic [NUM_BUTTONS-1:0] hold_flags, hold_flags_next;
  logic [NUM_BUTTONS-1:0] long_hold_flags, long_hold_flags_next;
  logic [31:0] hold_change_time, hold_change_time_next;
  logic        pair_valid, pair_valid_next;
  logic [1:0]  pair_button, pair_button_next;
  logic [1:0]  kickout_count, kickout_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_hold_us      <= PAIR_HOLD_RST;
      kickout_hold_us   <= KICKOUT_HOLD_RST;
      kickout_expire_us <= KICKOUT_EXPIRE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAIR_HOLD:      pair_hold_us      <= cfg_data;
        CFG_KICKOUT_HOLD:   kickout_hold_us   <= cfg_data;
        CFG_KICKOUT_EXPIRE: kickout_expire_us <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= load;
    end
    if (load) begin
      in_op     <= op_in;
      in_button <= button_in;
      in_now    <= now_in;
    end
  end

  assign busy = in_valid;

  logic [31:0]   elapsed;
  logic [2:0]    held_n;
  logic [BW-1:0] held_idx;
  logic          btn_ok;
  logic [BW-1:0] bidx;
  logic [1:0]    kc_tmp;
  result_t       r0, r1;
  logic [1:0]    nres;

  always_comb begin
    elapsed  = in_now - hold_change_time;
    held_n   = '0;
    held_idx = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      held_n = held_n + {2'b00, hold_flags[i]};
      if (hold_flags[i]) held_idx = BW'(i);
    end
    btn_ok = ({1'b0, in_button} < 3'(NUM_BUTTONS));
    bidx   = in_button[BW-1:0];

    hold_flags_next       = hold_flags;
    long_hold_flags_next  = long_hold_flags;
    hold_change_time_next = hold_change_time;
    pair_valid_next       = pair_valid;
    pair_button_next      = pair_button;
    kickout_count_next    = kickout_count;
    kc_tmp                = kickout_count;
    r0   = '{gesture: G_PRESS, which_button: 2'd0, last: 1'b1};
    r1   = '{gesture: G_PRESS, which_button: 2'd0, last: 1'b1};
    nres = 2'd0;

    if (in_valid) begin
      case (in_op)
        OP_TICK: begin
          if (held_n == 3'd1 && elapsed > pair_hold_us) begin
            hold_flags_next  = '0;
            pair_valid_next  = 1'b1;
            pair_button_next = 2'(held_idx);
            r0   = '{gesture: G_PAIR, which_button: 2'(held_idx), last: 1'b1};
            nres = 2'd1;
          end else if (held_n == 3'd2 && elapsed > kickout_hold_us) begin
            hold_flags_next = '0;
            if (kickout_count == KICKOUT_LIMIT - 2'd1) begin
              kc_tmp = 2'd0;
              r0     = '{gesture: G_KICKOUT, which_button: 2'd0, last: 1'b1};
            end else begin
              kc_tmp = kickout_count + 2'd1;
              r0     = '{gesture: G_KICKINC, which_button: 2'd0, last: 1'b1};
            end
            nres = 2'd1;
          end
          // idle expiry is checked on the updated count
          if (kc_tmp != 2'd0 && elapsed > kickout_expire_us) begin
            kickout_count_next = 2'd0;
          end else begin
            kickout_count_next = kc_tmp;
          end
        end
        OP_PRESS: begin
          if (btn_ok) begin
            r0   = '{gesture: G_PRESS, which_button: in_button, last: 1'b1};
            nres = 2'd1;
            if (pair_valid && pair_button == in_button) begin
              r0.last          = 1'b0;
              r1   = '{gesture: G_DELETE, which_button: in_button, last: 1'b1};
              nres = 2'd2;
              pair_valid_next  = 1'b0;
              pair_button_next = 2'd0;
            end
          end
        end
        OP_HOLD: begin
          if (btn_ok) begin
            hold_flags_next[bidx] = 1'b1;
            hold_change_time_next = in_now;
          end
        end
        OP_HOLD_REL: begin
          if (btn_ok) begin
            hold_flags_next[bidx] = 1'b0;
            hold_change_time_next = in_now;
          end
        end
        OP_LONG: begin
          if (btn_ok) begin
            hold_flags_next[bidx]      = 1'b0;
            long_hold_flags_next[bidx] = 1'b1;
            if (long_hold_flags_next[0] && long_hold_flags_next[1]) begin
              r0   = '{gesture: G_WIFI, which_button: 2'd0, last: 1'b1};
              nres = 2'd1;
            end
          end
        end
        OP_LONG_REL: begin
          if (btn_ok) long_hold_flags_next[bidx] = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign push = '{n: nres, r0: r0, r1: r1};

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_flags       <= '0;
      long_hold_flags  <= '0;
      hold_change_time <= '0;
      pair_valid       <= 1'b0;
      pair_button      <= 2'd0;
      kickout_count    <= 2'd0;
    end else begin
      hold_flags       <= hold_flags_next;
      long_hold_flags  <= long_hold_flags_next;
      hold_change_time <= hold_change_time_next;
      pair_valid       <= pair_valid_next;
      pair_button      <= pair_button_next;
      kickout_count    <= kickout_count_next;
    end
  end

endmodule

### hdl/bhg_queue.sv
`timescale 1ns / 1ps

module bhg_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  bhg_pkg::push_t         push,
  input  logic                   pop,
  output logic                   not_empty,
  output bhg_pkg::result_t       head,
  output logic [bhg_pkg::QCNT_W-1:0] count
);
  import bhg_pkg::*;

  result_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count_next;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.n == 2'd2) mem[wr_ptr + QPTR_W'(1)] <= push.r1;
  end

  assign count_next = count + QCNT_W'(push.n) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count  <= count_next;
    end
  end

  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

endmodule

### hdl/bhg_checker.sv
`timescale 1ns / 1ps

module bhg_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);
  import bhg_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'(G_KICKINC))
    else $error("gesture code out of range");

  // gestures without a button carry zero
  a_nobtn: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[2:0] == 3'(G_WIFI) || m_axis_tdata[2:0] == 3'(G_KICKOUT)
      || m_axis_tdata[2:0] == 3'(G_KICKINC)) |-> m_axis_tdata[4:3] == 2'd0)
    else $error("button field not zero");

  // delete always follows a press and ends the item; only the end of the item is asserted here
  a_delete: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] == 3'(G_DELETE) |-> m_axis_tlast)
    else $error("delete not last");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered after reset");

endmodule

bind button_hold_gesture_controller_core bhg_checker u_bhg_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
